FILE: rtl/gcas_pkg.sv
// shared types and constants for the grid crowd agent step block
package gcas_pkg;

   localparam int OPCODE_W    = 1;
   localparam int AGENT_W     = 8;
   localparam int COORD_W     = 6;
   localparam int OUTCOME_W   = 3;
   localparam int POS_W       = 14;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 6;

   localparam logic [OPCODE_W-1:0] OP_PLACE = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_STEP  = 1'b1;

   localparam logic [OUTCOME_W-1:0] OUT_MOVED    = 3'd0;
   localparam logic [OUTCOME_W-1:0] OUT_WAITED   = 3'd1;
   localparam logic [OUTCOME_W-1:0] OUT_EXITED   = 3'd2;
   localparam logic [OUTCOME_W-1:0] OUT_INACTIVE = 3'd3;
   localparam logic [OUTCOME_W-1:0] OUT_PLACED   = 3'd4;
   localparam logic [OUTCOME_W-1:0] OUT_REJECTED = 3'd5;

   localparam logic [CSR_INDEX_W-1:0] CSR_EXIT_X = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXIT_Y = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_OFFSET,
      ST_DIVIDE,
      ST_TARGET,
      ST_PROBE,
      ST_MOVE,
      ST_PLACE
   } state_type;

endpackage

FILE: rtl/grid_crowd_agent_step.sv
// grid crowd agent step: sequencer, occupancy map and agent table
// place: registered result strobe from the PLACE state, or from LOOKUP when rejected
// step: runs the bit-serial divider (one quotient bit a cycle) unless the offset to the exit is zero
// inactive agents answer from the LOOKUP state; one request at a time, busy high meanwhile
// after reset a sweep over max(GRID_W*GRID_H, NUM_AGENTS) addresses clears map and table
// the receiver cannot stall: each result is shown for one cycle on rsp_valid
module grid_crowd_agent_step #(
   parameter int GRID_W     = 64,
   parameter int GRID_H     = 64,
   parameter int NUM_AGENTS = 256,
   parameter int FRAC_BITS  = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [gcas_pkg::OPCODE_W-1:0]     req_opcode,
   input  logic [gcas_pkg::AGENT_W-1:0]      req_agent,
   input  logic [gcas_pkg::COORD_W-1:0]      req_place_x,
   input  logic [gcas_pkg::COORD_W-1:0]      req_place_y,
   output logic                              rsp_valid,
   output logic [gcas_pkg::AGENT_W-1:0]      rsp_agent_out,
   output logic [gcas_pkg::OUTCOME_W-1:0]    rsp_outcome,
   output logic [gcas_pkg::POS_W-1:0]        rsp_pos_x,
   output logic [gcas_pkg::POS_W-1:0]        rsp_pos_y,
   input  logic                              csr_we,
   input  logic [gcas_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [gcas_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import gcas_pkg::*;

   localparam int XW    = $clog2(GRID_W);
   localparam int YW    = $clog2(GRID_H);
   localparam int XYW   = (XW > YW) ? XW : YW;
   localparam int CW    = ((XYW > COORD_W) ? XYW : COORD_W) + 1;
   localparam int PW    = CW + FRAC_BITS;
   localparam int DW    = PW + 1;
   localparam int QW    = FRAC_BITS + 1;
   localparam int SPX   = XW + FRAC_BITS;
   localparam int SPY   = YW + FRAC_BITS;
   localparam int TW    = 1 + SPX + SPY;
   localparam int MAPD  = GRID_W * GRID_H;
   localparam int MAW   = $clog2(MAPD);
   localparam int AIW   = (NUM_AGENTS > 1) ? $clog2(NUM_AGENTS) : 1;
   localparam int CLR_N = (MAPD > NUM_AGENTS) ? MAPD : NUM_AGENTS;
   localparam int CLRW  = $clog2(CLR_N);
   localparam logic [QW-1:0] STEP_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   state_type state_ff, state_in;

   logic                  map_mem [MAPD];
   logic [TW-1:0]         tbl_mem [NUM_AGENTS];

   logic                  map_we, map_wdata, map_rd_ff;
   logic [MAW-1:0]        map_waddr, map_raddr;
   logic                  tbl_we, tbl_re;
   logic [AIW-1:0]        tbl_waddr, tbl_raddr;
   logic [TW-1:0]         tbl_wdata, tbl_rd_ff;

   logic [CLRW-1:0]       clr_ff, clr_in;
   logic [COORD_W-1:0]    exit_x_ff, exit_x_in, exit_y_ff, exit_y_in;

   logic [OPCODE_W-1:0]   op_ff, op_in;
   logic [AGENT_W-1:0]    agent_ff, agent_in;
   logic [COORD_W-1:0]    plx_ff, plx_in, ply_ff, ply_in;
   logic [DW-1:0]         dx_ff, dx_in, dy_ff, dy_in;
   logic                  sgnx_ff, sgnx_in, sgny_ff, sgny_in, xmaj_ff, xmaj_in;
   logic [PW-1:0]         nx_ff, nx_in, ny_ff, ny_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [AGENT_W-1:0]    rsp_agent_ff, rsp_agent_in;
   logic [OUTCOME_W-1:0]  rsp_outcome_ff, rsp_outcome_in;
   logic [POS_W-1:0]      rsp_pos_x_ff, rsp_pos_x_in, rsp_pos_y_ff, rsp_pos_y_in;

   logic                  agent_ok, ent_valid;
   logic [SPX-1:0]        ent_x, pl_px;
   logic [SPY-1:0]        ent_y, pl_py;
   logic [MAW-1:0]        old_cell, pl_cell, tg_cell;
   logic                  pl_reject;
   logic [CW-1:0]         tx, ty;
   logic                  tg_exit, tg_off;
   logic [DW-1:0]         ex_pos, ey_pos;
   logic [PW-1:0]         adx, ady, mag_max, mag_min;
   logic                  mzero, clr_last;
   logic                  div_load, div_done;
   logic [QW-1:0]         div_q, stepx, stepy;
   logic [DW-1:0]         sumx, sumy;

   function automatic logic [MAW-1:0] cell_addr(input logic [CW-1:0] cx,
                                                input logic [CW-1:0] cy);
      return MAW'(MAW'(cy) * MAW'(GRID_W)) + MAW'(cx);
   endfunction

   gcas_div #(
      .NW        (PW),
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .load  (div_load),
      .num   (mag_min),
      .den   (mag_max),
      .done  (div_done),
      .quot  (div_q)
   );

   // decode of the current request
   always_comb begin
      agent_ok  = int'(agent_ff) < NUM_AGENTS;
      ent_valid = tbl_rd_ff[TW-1] && agent_ok;
      ent_x     = tbl_rd_ff[TW-2 -: SPX];
      ent_y     = tbl_rd_ff[SPY-1:0];
      old_cell  = cell_addr(CW'(ent_x >> FRAC_BITS), CW'(ent_y >> FRAC_BITS));
      pl_cell   = cell_addr(CW'(plx_ff), CW'(ply_ff));
      pl_px     = SPX'(plx_ff) << FRAC_BITS;
      pl_py     = SPY'(ply_ff) << FRAC_BITS;
      pl_reject = !agent_ok || (CW'(plx_ff) >= CW'(GRID_W)) || (CW'(ply_ff) >= CW'(GRID_H))
                  || ((plx_ff == exit_x_ff) && (ply_ff == exit_y_ff)) || map_rd_ff;
      tx        = CW'(nx_ff >> FRAC_BITS);
      ty        = CW'(ny_ff >> FRAC_BITS);
      tg_exit   = (tx == CW'(exit_x_ff)) && (ty == CW'(exit_y_ff));
      tg_off    = (tx >= CW'(GRID_W)) || (ty >= CW'(GRID_H));
      tg_cell   = cell_addr(tx, ty);
      ex_pos    = DW'(exit_x_ff) << FRAC_BITS;
      ey_pos    = DW'(exit_y_ff) << FRAC_BITS;
      adx       = dx_ff[DW-1] ? PW'(-dx_ff) : PW'(dx_ff);
      ady       = dy_ff[DW-1] ? PW'(-dy_ff) : PW'(dy_ff);
      mag_max   = (adx > ady) ? adx : ady;
      mag_min   = (adx > ady) ? ady : adx;
      mzero     = mag_max == '0;
      stepx     = xmaj_ff ? STEP_ONE : div_q;
      stepy     = xmaj_ff ? div_q : STEP_ONE;
      sumx      = sgnx_ff ? DW'(ent_x) - DW'(stepx) : DW'(ent_x) + DW'(stepx);
      sumy      = sgny_ff ? DW'(ent_y) - DW'(stepy) : DW'(ent_y) + DW'(stepy);
      clr_last  = clr_ff == CLRW'(CLR_N - 1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (clr_last) state_in = ST_IDLE;
         ST_IDLE:   if (start) state_in = ST_LOOKUP;
         ST_LOOKUP: begin
            if (op_ff == OP_PLACE) begin
               state_in = pl_reject ? ST_IDLE : ST_PLACE;
            end else begin
               state_in = ent_valid ? ST_OFFSET : ST_IDLE;
            end
         end
         ST_OFFSET: state_in = mzero ? ST_TARGET : ST_DIVIDE;
         ST_DIVIDE: if (div_done) state_in = ST_TARGET;
         ST_TARGET: state_in = (tg_exit || tg_off) ? ST_IDLE : ST_PROBE;
         ST_PROBE:  state_in = map_rd_ff ? ST_IDLE : ST_MOVE;
         ST_MOVE:   state_in = ST_IDLE;
         ST_PLACE:  state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      clr_in         = clr_ff;
      op_in          = op_ff;
      agent_in       = agent_ff;
      plx_in         = plx_ff;
      ply_in         = ply_ff;
      dx_in          = dx_ff;
      dy_in          = dy_ff;
      sgnx_in        = sgnx_ff;
      sgny_in        = sgny_ff;
      xmaj_in        = xmaj_ff;
      nx_in          = nx_ff;
      ny_in          = ny_ff;
      rsp_valid_in   = 1'b0;
      rsp_agent_in   = rsp_agent_ff;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_pos_x_in   = rsp_pos_x_ff;
      rsp_pos_y_in   = rsp_pos_y_ff;
      map_we         = 1'b0;
      map_waddr      = old_cell;
      map_wdata      = 1'b0;
      map_raddr      = cell_addr(CW'(req_place_x), CW'(req_place_y));
      tbl_we         = 1'b0;
      tbl_re         = 1'b0;
      tbl_waddr      = AIW'(agent_ff);
      tbl_wdata      = '0;
      tbl_raddr      = AIW'(req_agent);
      div_load       = 1'b0;
      exit_x_in      = exit_x_ff;
      exit_y_in      = exit_y_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_EXIT_X: exit_x_in = csr_wdata;
            CSR_EXIT_Y: exit_y_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_in    = clr_ff + 1'b1;
            map_we    = int'(clr_ff) < MAPD;
            map_waddr = clr_ff[MAW-1:0];
            tbl_we    = int'(clr_ff) < NUM_AGENTS;
            tbl_waddr = clr_ff[AIW-1:0];
         end
         ST_IDLE: begin
            if (start) begin
               tbl_re   = 1'b1;
               op_in    = req_opcode;
               agent_in = req_agent;
               plx_in   = req_place_x;
               ply_in   = req_place_y;
            end
         end
         ST_LOOKUP: begin
            rsp_agent_in = agent_ff;
            rsp_pos_x_in = '0;
            rsp_pos_y_in = '0;
            if (op_ff == OP_PLACE) begin
               if (pl_reject) begin
                  rsp_valid_in   = 1'b1;
                  rsp_outcome_in = OUT_REJECTED;
                  if (ent_valid) begin
                     rsp_pos_x_in = POS_W'(ent_x);
                     rsp_pos_y_in = POS_W'(ent_y);
                  end
               end else begin
                  map_we    = ent_valid;
                  tbl_we    = 1'b1;
                  tbl_wdata = {1'b1, pl_px, pl_py};
               end
            end else begin
               dx_in = ex_pos - DW'(ent_x);
               dy_in = ey_pos - DW'(ent_y);
               if (!ent_valid) begin
                  rsp_valid_in   = 1'b1;
                  rsp_outcome_in = OUT_INACTIVE;
               end
            end
         end
         ST_OFFSET: begin
            sgnx_in  = dx_ff[DW-1];
            sgny_in  = dy_ff[DW-1];
            xmaj_in  = adx > ady;
            div_load = !mzero;
            nx_in    = PW'(ent_x);
            ny_in    = PW'(ent_y);
         end
         ST_DIVIDE: begin
            if (div_done) begin
               nx_in = sumx[DW-1] ? '0 : sumx[PW-1:0];
               ny_in = sumy[DW-1] ? '0 : sumy[PW-1:0];
            end
         end
         ST_TARGET: begin
            map_raddr    = tg_cell;
            rsp_agent_in = agent_ff;
            if (tg_exit) begin
               map_we         = 1'b1;
               tbl_we         = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = OUT_EXITED;
               rsp_pos_x_in   = '0;
               rsp_pos_y_in   = '0;
            end else if (tg_off) begin
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = OUT_WAITED;
               rsp_pos_x_in   = POS_W'(ent_x);
               rsp_pos_y_in   = POS_W'(ent_y);
            end
         end
         ST_PROBE: begin
            if (map_rd_ff) begin
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = OUT_WAITED;
               rsp_pos_x_in   = POS_W'(ent_x);
               rsp_pos_y_in   = POS_W'(ent_y);
            end else begin
               map_we    = 1'b1;
               tbl_we    = 1'b1;
               tbl_wdata = {1'b1, SPX'(nx_ff), SPY'(ny_ff)};
            end
         end
         ST_MOVE: begin
            map_we         = 1'b1;
            map_waddr      = tg_cell;
            map_wdata      = 1'b1;
            rsp_valid_in   = 1'b1;
            rsp_outcome_in = OUT_MOVED;
            rsp_pos_x_in   = POS_W'(nx_ff);
            rsp_pos_y_in   = POS_W'(ny_ff);
         end
         ST_PLACE: begin
            map_we         = 1'b1;
            map_waddr      = pl_cell;
            map_wdata      = 1'b1;
            rsp_valid_in   = 1'b1;
            rsp_outcome_in = OUT_PLACED;
            rsp_pos_x_in   = POS_W'(pl_px);
            rsp_pos_y_in   = POS_W'(pl_py);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         exit_x_ff    <= '0;
         exit_y_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         exit_x_ff    <= exit_x_in;
         exit_y_ff    <= exit_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      agent_ff       <= agent_in;
      plx_ff         <= plx_in;
      ply_ff         <= ply_in;
      dx_ff          <= dx_in;
      dy_ff          <= dy_in;
      sgnx_ff        <= sgnx_in;
      sgny_ff        <= sgny_in;
      xmaj_ff        <= xmaj_in;
      nx_ff          <= nx_in;
      ny_ff          <= ny_in;
      rsp_agent_ff   <= rsp_agent_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_pos_x_ff   <= rsp_pos_x_in;
      rsp_pos_y_ff   <= rsp_pos_y_in;
   end

   // occupancy map
   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= map_wdata;
      end
      map_rd_ff <= map_mem[map_raddr];
   end

   // agent table
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_waddr] <= tbl_wdata;
      end
      if (tbl_re) begin
         tbl_rd_ff <= tbl_mem[tbl_raddr];
      end
   end

   assign busy          = state_ff != ST_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_agent_out = rsp_agent_ff;
   assign rsp_outcome   = rsp_outcome_ff;
   assign rsp_pos_x     = rsp_pos_x_ff;
   assign rsp_pos_y     = rsp_pos_y_ff;

endmodule

FILE: rtl/gcas_div.sv
// bit-serial restoring divider for the minor-axis step fraction
module gcas_div #(
   parameter int NW        = 16,
   parameter int FRAC_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  logic [NW-1:0]      num,
   input  logic [NW-1:0]      den,
   output logic               done,
   output logic [FRAC_BITS:0] quot
);

   localparam int QW   = FRAC_BITS + 1;
   localparam int CNTW = $clog2(QW);

   logic [NW:0]     rem_ff, rem_in;
   logic [NW-1:0]   den_ff, den_in;
   logic [QW-1:0]   quo_ff, quo_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            run_ff, run_in;
   logic            done_ff, done_in;
   logic [NW:0]     diff;
   logic            ge;

   always_comb begin
      diff    = rem_ff - {1'b0, den_ff};
      ge      = rem_ff >= {1'b0, den_ff};
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (load) begin
         rem_in = {1'b0, num};
         den_in = den;
         quo_in = '0;
         cnt_in = CNTW'(FRAC_BITS);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = {(ge ? diff[NW-1:0] : rem_ff[NW-1:0]), 1'b0};
         quo_in = {quo_ff[QW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

FILE: tb/testbench.sv
// testbench for grid_crowd_agent_step: predicted agent moves checked against every response
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import gcas_pkg::*;

   localparam int GRID_W       = 64;
   localparam int GRID_H       = 64;
   localparam int NUM_AGENTS   = 256;
   localparam int FRAC_BITS    = 8;
   localparam int IDLE_LIMIT   = 20000;
   localparam int RANDOM_ITEMS = 1225;
   localparam int PHASE_LEN    = 150;
   localparam int QUIET_TAIL   = 200;
   localparam int CROWD        = 12;
   localparam int SETTLE       = 24;

   typedef struct packed {
      logic [AGENT_W-1:0]   agent;
      logic [OUTCOME_W-1:0] outcome;
      logic [POS_W-1:0]     pos_x;
      logic [POS_W-1:0]     pos_y;
   } agent_outcome_type;

   class crowd_scoreboard_type;
      bit                occupied [GRID_W*GRID_H];
      bit                active [NUM_AGENTS];
      longint            at_x [NUM_AGENTS];
      longint            at_y [NUM_AGENTS];
      int                exit_col;
      int                exit_row;
      agent_outcome_type awaited_outcomes [$];
      int                mismatches;

      function new();
         exit_col   = 0;
         exit_row   = 0;
         mismatches = 0;
      endfunction

      function void set_exit(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         if (idx == CSR_EXIT_X) begin
            exit_col = int'(val);
         end else if (idx == CSR_EXIT_Y) begin
            exit_row = int'(val);
         end
      endfunction

      function int cell_of(longint cx, longint cy);
         return int'(cy) * GRID_W + int'(cx);
      endfunction

      // signed share of one cell along d, truncated toward zero
      function longint step_share(longint d, longint m);
         longint q;
         q = ((d < 0 ? -d : d) << FRAC_BITS) / m;
         return (d < 0) ? -q : q;
      endfunction

      function void note_request(logic [OPCODE_W-1:0] op, logic [AGENT_W-1:0] agent,
                                 logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy);
         agent_outcome_type r;
         longint px, py, dx, dy, adx, ady, m, nx, ny, tx, ty;
         r.agent = agent;
         r.pos_x = '0;
         r.pos_y = '0;
         if (op == OP_PLACE) begin
            if ((cx == exit_col && cy == exit_row) ||
                occupied[cell_of(longint'(cx), longint'(cy))]) begin
               r.outcome = OUT_REJECTED;
               if (active[agent]) begin
                  r.pos_x = at_x[agent][POS_W-1:0];
                  r.pos_y = at_y[agent][POS_W-1:0];
               end
            end else begin
               if (active[agent])
                  occupied[cell_of(at_x[agent] >> FRAC_BITS, at_y[agent] >> FRAC_BITS)] = 1'b0;
               occupied[cell_of(longint'(cx), longint'(cy))] = 1'b1;
               active[agent] = 1'b1;
               at_x[agent]   = longint'(cx) << FRAC_BITS;
               at_y[agent]   = longint'(cy) << FRAC_BITS;
               r.outcome     = OUT_PLACED;
               r.pos_x       = at_x[agent][POS_W-1:0];
               r.pos_y       = at_y[agent][POS_W-1:0];
            end
         end else if (!active[agent]) begin
            r.outcome = OUT_INACTIVE;
         end else begin
            px  = at_x[agent];
            py  = at_y[agent];
            dx  = (longint'(exit_col) << FRAC_BITS) - px;
            dy  = (longint'(exit_row) << FRAC_BITS) - py;
            adx = dx < 0 ? -dx : dx;
            ady = dy < 0 ? -dy : dy;
            m   = adx > ady ? adx : ady;
            nx  = px;
            ny  = py;
            if (m != 0) begin
               nx = px + step_share(dx, m);
               ny = py + step_share(dy, m);
            end
            if (nx < 0) nx = 0;
            if (ny < 0) ny = 0;
            tx = nx >> FRAC_BITS;
            ty = ny >> FRAC_BITS;
            if (tx == exit_col && ty == exit_row) begin
               occupied[cell_of(px >> FRAC_BITS, py >> FRAC_BITS)] = 1'b0;
               active[agent] = 1'b0;
               at_x[agent]   = 0;
               at_y[agent]   = 0;
               r.outcome     = OUT_EXITED;
            end else if (tx >= GRID_W || ty >= GRID_H || occupied[cell_of(tx, ty)]) begin
               r.outcome = OUT_WAITED;
               r.pos_x   = px[POS_W-1:0];
               r.pos_y   = py[POS_W-1:0];
            end else begin
               occupied[cell_of(px >> FRAC_BITS, py >> FRAC_BITS)] = 1'b0;
               occupied[cell_of(tx, ty)] = 1'b1;
               at_x[agent] = nx;
               at_y[agent] = ny;
               r.outcome   = OUT_MOVED;
               r.pos_x     = nx[POS_W-1:0];
               r.pos_y     = ny[POS_W-1:0];
            end
         end
         awaited_outcomes.push_back(r);
      endfunction

      task report_mismatch(string msg);
         $display("%0t ns: %s", $time, msg);
         mismatches++;
      endtask

      task check_result(logic [AGENT_W-1:0] agent, logic [OUTCOME_W-1:0] outcome,
                        logic [POS_W-1:0] pos_x, logic [POS_W-1:0] pos_y);
         agent_outcome_type want;
         if (awaited_outcomes.size() == 0) begin
            report_mismatch($sformatf("response for agent %0d with no request pending", agent));
         end else begin
            want = awaited_outcomes.pop_front();
            if (agent !== want.agent)
               report_mismatch($sformatf("agent_out %0d, expected %0d", agent, want.agent));
            if (outcome !== want.outcome)
               report_mismatch($sformatf("agent %0d outcome %0d, expected %0d",
                                         want.agent, outcome, want.outcome));
            if (pos_x !== want.pos_x)
               report_mismatch($sformatf("agent %0d pos_x %0d, expected %0d",
                                         want.agent, pos_x, want.pos_x));
            if (pos_y !== want.pos_y)
               report_mismatch($sformatf("agent %0d pos_y %0d, expected %0d",
                                         want.agent, pos_y, want.pos_y));
         end
      endtask
   endclass

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [OPCODE_W-1:0]    req_opcode;
   logic [AGENT_W-1:0]     req_agent;
   logic [COORD_W-1:0]     req_place_x;
   logic [COORD_W-1:0]     req_place_y;
   logic                   rsp_valid;
   logic [AGENT_W-1:0]     rsp_agent_out;
   logic [OUTCOME_W-1:0]   rsp_outcome;
   logic [POS_W-1:0]       rsp_pos_x;
   logic [POS_W-1:0]       rsp_pos_y;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   crowd_scoreboard_type   sb;
   logic [AGENT_W-1:0]     crowd [CROWD];
   int                     idle_cycles = 0;

   grid_crowd_agent_step #(
      .GRID_W(GRID_W),
      .GRID_H(GRID_H),
      .NUM_AGENTS(NUM_AGENTS),
      .FRAC_BITS(FRAC_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_agent(req_agent),
      .req_place_x(req_place_x),
      .req_place_y(req_place_y),
      .rsp_valid(rsp_valid),
      .rsp_agent_out(rsp_agent_out),
      .rsp_outcome(rsp_outcome),
      .rsp_pos_x(rsp_pos_x),
      .rsp_pos_y(rsp_pos_y),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         sb.check_result(rsp_agent_out, rsp_outcome, rsp_pos_x, rsp_pos_y);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("grid_crowd_agent_step verification failed");
            $finish;
         end
      end
   end

   task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [AGENT_W-1:0] agent,
                               input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy);
      req_opcode  <= op;
      req_agent   <= agent;
      req_place_x <= cx;
      req_place_y <= cy;
      start       <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(op, agent, cx, cy);
   endtask

   task automatic pause_sender(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (sb.awaited_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_exit_cell(input logic [CSR_DATA_W-1:0] col,
                                input logic [CSR_DATA_W-1:0] row);
      drain_results();
      csr_we    <= 1'b1;
      csr_index <= CSR_EXIT_X;
      csr_wdata <= col;
      @(posedge clock);
      sb.set_exit(CSR_EXIT_X, col);
      csr_index <= CSR_EXIT_Y;
      csr_wdata <= row;
      @(posedge clock);
      sb.set_exit(CSR_EXIT_Y, row);
      csr_we <= 1'b0;
   endtask

   function automatic logic [COORD_W-1:0] near_exit(input int c);
      int v;
      v = c + int'($urandom_range(0, 8)) - 4;
      if (v < 0) v = 0;
      if (v > GRID_W - 1) v = GRID_W - 1;
      return v[COORD_W-1:0];
   endfunction

   task automatic random_request();
      int                 pick;
      logic [AGENT_W-1:0] agent;
      logic [COORD_W-1:0] cx;
      logic [COORD_W-1:0] cy;
      pick  = int'($urandom_range(0, 99));
      agent = crowd[$urandom_range(0, CROWD - 1)];
      cx    = COORD_W'($urandom_range(0, GRID_W - 1));
      cy    = COORD_W'($urandom_range(0, GRID_H - 1));
      if (pick < 26) begin
         if ($urandom_range(0, 1)) begin
            cx = near_exit(sb.exit_col);
            cy = near_exit(sb.exit_row);
         end
         send_request(OP_PLACE, agent, cx, cy);
      end else if (pick < 86) begin
         send_request(OP_STEP, agent, cx, cy);
      end else if (pick < 93) begin
         send_request(OP_STEP, AGENT_W'($urandom_range(0, 255)), cx, cy);
      end else begin
         send_request(OP_PLACE, AGENT_W'($urandom_range(0, 255)), cx, cy);
      end
   endtask

   initial begin
      int phase;
      int sent;
      bit quiet;
      sb          = new();
      reset       = 1'b1;
      start       = 1'b0;
      req_opcode  = OP_PLACE;
      req_agent   = '0;
      req_place_x = '0;
      req_place_y = '0;
      csr_we      = 1'b0;
      csr_index   = CSR_EXIT_X;
      csr_wdata   = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (busy) @(posedge clock);

      set_exit_cell(6'd0, 6'd0);
      send_request(OP_STEP, 8'd0, 6'd0, 6'd0);
      send_request(OP_STEP, 8'd255, 6'd63, 6'd63);
      send_request(OP_PLACE, 8'd0, 6'd0, 6'd0);
      send_request(OP_PLACE, 8'd0, 6'd63, 6'd63);
      send_request(OP_PLACE, 8'd255, 6'd63, 6'd63);
      send_request(OP_PLACE, 8'd0, 6'd63, 6'd63);
      send_request(OP_PLACE, 8'd0, 6'd62, 6'd63);
      send_request(OP_PLACE, 8'd1, 6'd1, 6'd1);
      send_request(OP_PLACE, 8'd2, 6'd2, 6'd2);
      send_request(OP_STEP, 8'd2, 6'd0, 6'd0);
      send_request(OP_STEP, 8'd1, 6'd0, 6'd0);
      send_request(OP_STEP, 8'd1, 6'd0, 6'd0);
      send_request(OP_STEP, 8'd2, 6'd0, 6'd0);
      send_request(OP_STEP, 8'd2, 6'd0, 6'd0);
      // fractional path, then exit moves onto and past the agent so x goes below zero
      send_request(OP_PLACE, 8'd10, 6'd4, 6'd3);
      send_request(OP_STEP, 8'd10, 6'd0, 6'd0);
      send_request(OP_STEP, 8'd10, 6'd0, 6'd0);
      set_exit_cell(6'd0, 6'd1);
      send_request(OP_STEP, 8'd10, 6'd0, 6'd0);
      set_exit_cell(6'd0, 6'd3);
      send_request(OP_STEP, 8'd10, 6'd0, 6'd0);
      set_exit_cell(6'd0, 6'd2);
      send_request(OP_STEP, 8'd10, 6'd0, 6'd0);
      send_request(OP_STEP, 8'd10, 6'd0, 6'd0);
      // exit placed on an occupied cell wins over occupancy
      send_request(OP_PLACE, 8'd20, 6'd5, 6'd5);
      send_request(OP_PLACE, 8'd21, 6'd6, 6'd6);
      set_exit_cell(6'd5, 6'd5);
      send_request(OP_STEP, 8'd21, 6'd0, 6'd0);
      send_request(OP_STEP, 8'd20, 6'd0, 6'd0);

      phase = 0;
      sent  = 0;
      while (sent < RANDOM_ITEMS) begin
         case (phase)
            0:       set_exit_cell(6'd63, 6'd63);
            1:       set_exit_cell(6'd0, 6'd63);
            2:       set_exit_cell(6'd63, 6'd0);
            3:       set_exit_cell(6'd0, 6'd0);
            default: set_exit_cell(CSR_DATA_W'($urandom_range(0, 63)),
                                   CSR_DATA_W'($urandom_range(0, 63)));
         endcase
         for (int k = 0; k < CROWD; k++) begin
            if (phase == 0 || $urandom_range(0, 1)) crowd[k] = AGENT_W'($urandom_range(0, 255));
         end
         quiet = (phase % 3 == 2);
         for (int n = 0; n < PHASE_LEN && sent < RANDOM_ITEMS; n++) begin
            random_request();
            sent++;
            if (!quiet && RANDOM_ITEMS - sent > QUIET_TAIL && $urandom_range(0, 2) == 0)
               pause_sender(int'($urandom_range(1, 14)));
         end
         phase++;
      end

      drain_results();
      if (sb.mismatches == 0) begin
         $display("grid_crowd_agent_step verification clean");
      end else begin
         $display("grid_crowd_agent_step verification failed");
      end
      $finish;
   end

endmodule
